// ===== hdl/sfpr_pkg.sv =====
// Shared types and constants for the sync-framed packet receiver.
package sfpr_pkg;

  // Sync pattern that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Type table geometry
  localparam int TYPE_COUNT = 10;
  localparam int PAIR_COUNT = 5;
  localparam int CFG_AW     = 3;
  localparam logic [15:0] MIN_FRAME_SIZE = 16'd4;

  // Input word kinds (in_tuser)
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Output word kinds (out_tuser)
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Type table answer for one class/id key
  typedef struct packed {
    logic        hit;
    logic [3:0]  type_idx;
    logic [15:0] size;
  } sfpr_lookup_t;

  // Accepted-frame report from the frame controller
  typedef struct packed {
    logic       valid;
    logic [3:0] type_idx;
    logic [7:0] length;
  } sfpr_frame_rpt_t;

endpackage

// ===== hdl/sync_framed_packet_receiver_core.sv =====
// Top level of the sync-framed packet receiver with result pipeline.
// Throughput: one input word per cycle, push or read, sustained while out_tready stays high.
// A result word is registered in stage one (with the frame buffer read port)
// and then in the output register.
// Reset: synchronous, active-low rst_n; clears the type table, the hunt
// state and the output valid; the frame buffer is not cleared.
module sync_framed_packet_receiver_core #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,  // rx_byte[7:0], read_index[14:8], zero
  input  logic                        in_tuser,  // action[0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata, // frame_type[3:0], frame_length[11:4],
                                                 // read_data[19:12], zero
  output logic                        out_tuser, // result_kind[0]
  input  logic                        cfg_we,
  input  logic [sfpr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [63:0]                 cfg_wdata
);
  import sfpr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  logic            in_fire;
  logic            is_read;
  logic [7:0]      rx_byte;
  logic [6:0]      read_index;
  sfpr_lookup_t    lookup;
  sfpr_frame_rpt_t rpt;
  logic [7:0]      class_q;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [7:0]      rd_data;

  logic            s1_v_r;
  logic            s1_kind_r;
  logic [3:0]      s1_type_r;
  logic [7:0]      s1_len_r;
  logic            s1_inrange_r;
  logic            s1_adv;

  logic            out_v_r;
  logic            out_kind_r;
  logic [3:0]      out_type_r;
  logic [7:0]      out_len_r;
  logic [7:0]      out_data_r;

  // Unpack the input word
  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[14:8];
  assign is_read    = (in_tuser == ACT_READ);

  // Stage one moves on whenever the output register is free or draining
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  sfpr_type_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .key_class (class_q),
    .key_id    (rx_byte),
    .lookup    (lookup)
  );

  sfpr_frame_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_fire && !is_read),
    .rx_byte (rx_byte),
    .lookup  (lookup),
    .class_q (class_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rpt     (rpt)
  );

  sfpr_frame_buf #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire && is_read),
    .rd_addr (AW'(read_index)),
    .rd_data (rd_data)
  );

  // Stage one: hold the result while the buffer read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= is_read || rpt.valid;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= is_read ? KIND_READ : KIND_FRAME;
      s1_type_r    <= is_read ? 4'd0 : rpt.type_idx;
      s1_len_r     <= is_read ? 8'd0 : rpt.length;
      s1_inrange_r <= (32'(read_index) < BUFFER_BYTES);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_kind_r <= s1_kind_r;
      out_type_r <= s1_type_r;
      out_len_r  <= s1_len_r;
      out_data_r <= ((s1_kind_r == KIND_READ) && s1_inrange_r) ? rd_data : 8'd0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_data_r, out_len_r, out_type_r};

`ifndef SYNTHESIS
  a_read_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_read) |=> s1_v_r)
    else $error("accepted read produced no pending result");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> !in_tready)
    else $error("input taken while stage one is stalled");
  a_result_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_v_r)
    else $error("pending result lost on its way to the output");
`endif

endmodule

// ===== hdl/sfpr_type_table.sv =====
// Type table registers and first-match class/id lookup.
module sfpr_type_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sfpr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [63:0]                 cfg_wdata,
  input  logic [7:0]                  key_class,
  input  logic [7:0]                  key_id,
  output sfpr_pkg::sfpr_lookup_t      lookup
);
  import sfpr_pkg::*;

  logic [63:0] pair_r [PAIR_COUNT];
  logic [TYPE_COUNT-1:0] match;
  logic [31:0] entry [TYPE_COUNT];

  // Write one register pair; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
        pair_r[p] <= '0;
      end
    end else if (cfg_we && (32'(cfg_addr) < PAIR_COUNT)) begin
      pair_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Compare all entries in parallel; tiny sizes disable an entry
  always_comb begin
    for (int e = 0; e < TYPE_COUNT; e++) begin
      entry[e] = pair_r[e >> 1][(e % 2) * 32 +: 32];
      match[e] = (entry[e][15:0] >= MIN_FRAME_SIZE) &&
                 (entry[e][31:24] == key_class) && (entry[e][23:16] == key_id);
    end
  end

  // Pick the lowest matching entry
  always_comb begin
    lookup = '0;
    for (int e = TYPE_COUNT - 1; e >= 0; e--) begin
      if (match[e]) begin
        lookup.hit      = 1'b1;
        lookup.type_idx = 4'(e);
        lookup.size     = entry[e][15:0];
      end
    end
  end

endmodule

// ===== hdl/sfpr_frame_buf.sv =====
// Frame byte memory: one write port, one registered read port.
module sfpr_frame_buf #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Store a frame byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sfpr_frame_ctrl.sv =====
// Sync hunt, frame position tracking and Fletcher checksum check.
module sfpr_frame_ctrl #(
  parameter int BUFFER_BYTES = 128,
  parameter int AW           = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [7:0]                  rx_byte,
  input  sfpr_pkg::sfpr_lookup_t      lookup,
  output logic [7:0]                  class_q,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [7:0]                  wr_data,
  output sfpr_pkg::sfpr_frame_rpt_t   rpt
);
  import sfpr_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES + 5);
  localparam int SW = $clog2(BUFFER_BYTES + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] exp_size_r, exp_size_nxt;
  logic [3:0]    mtype_r, mtype_nxt;
  logic [7:0]    sum_a_r, sum_a_nxt;
  logic [7:0]    sum_b_r, sum_b_nxt;
  logic [7:0]    class_r, class_nxt;
  logic [PW-1:0] idx;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] end_a;
  logic [PW-1:0] end_b;
  logic          store;
  logic          emit;
  logic [SW-1:0] lk_size;
  logic [15:0]   size_ext;

  // Clamp table sizes to the buffer depth
  assign lk_size = (lookup.size > 16'(BUFFER_BYTES)) ? SW'(BUFFER_BYTES) : SW'(lookup.size);
  assign class_q = class_r;

  // Advance the frame state for one pushed byte
  always_comb begin
    pos_nxt      = pos_r;
    exp_size_nxt = exp_size_r;
    mtype_nxt    = mtype_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    class_nxt    = class_r;
    idx          = pos_r - PW'(2);
    pos_inc      = pos_r + PW'(1);
    store        = 1'b0;
    emit         = 1'b0;
    end_a        = '0;
    end_b        = '0;
    if (push) begin
      case (pos_r)
        PW'(0): begin
          pos_nxt = (rx_byte == SYNC_FIRST) ? PW'(1) : PW'(0);
        end
        PW'(1): begin
          if (rx_byte == SYNC_SECOND) begin
            pos_nxt   = PW'(2);
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end else begin
            pos_nxt = PW'(0);
          end
        end
        default: begin
          store = (idx < PW'(exp_size_r));
          if (store) begin
            sum_a_nxt = sum_a_r + rx_byte;
            sum_b_nxt = sum_b_r + sum_a_nxt;
          end
          if (pos_r == PW'(2)) begin
            class_nxt = rx_byte;
          end
          pos_nxt = pos_inc;
          if ((pos_inc == PW'(4)) && !lookup.hit) begin
            pos_nxt = PW'(0);
          end else begin
            if (pos_inc == PW'(4)) begin
              mtype_nxt    = lookup.type_idx;
              exp_size_nxt = lk_size;
            end
            end_a = PW'(exp_size_nxt) + PW'(3);
            end_b = PW'(exp_size_nxt) + PW'(4);
            if (pos_inc == end_a) begin
              if (rx_byte != sum_a_nxt) begin
                pos_nxt = PW'(0);
              end
            end else if (pos_inc == end_b) begin
              pos_nxt = PW'(0);
              emit    = (rx_byte == sum_b_nxt);
            end else if (pos_inc > end_b) begin
              pos_nxt = PW'(0);
            end
          end
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      exp_size_r <= SW'(BUFFER_BYTES);
      mtype_r    <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      class_r    <= '0;
    end else begin
      pos_r      <= pos_nxt;
      exp_size_r <= exp_size_nxt;
      mtype_r    <= mtype_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      class_r    <= class_nxt;
    end
  end

  // Buffer write and frame report
  assign wr_en        = store;
  assign wr_addr      = AW'(idx);
  assign wr_data      = rx_byte;
  assign size_ext     = 16'(exp_size_nxt);
  assign rpt.valid    = emit;
  assign rpt.type_idx = mtype_nxt;
  assign rpt.length   = size_ext[7:0];

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(exp_size_r) + PW'(4))
    else $error("frame position past checksum bytes");
  a_emit_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (pos_r == PW'(exp_size_r) + PW'(3)))
    else $error("frame reported away from second checksum byte");
  a_store_in_buf: assert property (@(posedge clk) disable iff (!rst_n)
    store |-> (idx < PW'(BUFFER_BYTES)))
    else $error("buffer write beyond depth");
`endif

endmodule
